>>> hdl/tension_spring_damper_force_unit_defines.svh
// ----------------------------------------------------------------------------
// Tension spring-damper force unit: assertion macros
// Concurrent check wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TENSION_SPRING_DAMPER_FORCE_UNIT_DEFINES_SVH
`define TENSION_SPRING_DAMPER_FORCE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define TSDF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tsdf assertion failed");
`define TSDF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tsdf implication failed");
`define TSDF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tsdf next-cycle check failed");
`else
`define TSDF_ASSERT(lbl, prop)
`define TSDF_ASSERT_IMP(lbl, ante, cons)
`define TSDF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> hdl/tsdf_pkg.sv
// ----------------------------------------------------------------------------
// Tension spring-damper force package
// Register indexes, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package tsdf_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_REST_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_STIFFNESS   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DAMPING     = 2'd2;

  localparam logic OP_PRIME = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [31:0] REST_LENGTH_RST = 32'h0001_0000;
  localparam logic [31:0] STIFFNESS_RST   = 32'h0001_0000;
  localparam logic [31:0] DAMPING_RST     = 32'h0000_0000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_MUL,
    S_SQ_ACC,
    S_LEN,
    S_SQRT,
    S_CHECK,
    S_SP_MUL,
    S_SP_LOAD,
    S_SP_DIV,
    S_DM_MUL,
    S_DM_LOAD,
    S_DM_DIV,
    S_TENSION,
    S_F_LO,
    S_F_HI,
    S_F_LOAD,
    S_F_DIV,
    S_F_SAT,
    S_DONE
  } state_e;

endpackage

>>> hdl/tension_spring_damper_force_unit.sv
// One item at a time. A taut step adds divisions for the spring term, the
// damping term (given a last length) and each force axis to the length work.
// The cost is set by one shared 1-bit-per-cycle restoring divider
// (64-bit quotients for the terms, 96-bit for each force axis) and a
// 2-bit-per-cycle square root. A new item is taken while a result waits.
// Reset (async, active low) restores default registers, clears last length.
// ----------------------------------------------------------------------------
// Tension spring-damper force unit
// Tension-only rope force between two bodies, one shared multiplier and
// divider under a small sequencer.
// ----------------------------------------------------------------------------
`include "tension_spring_damper_force_unit_defines.svh"

module tension_spring_damper_force_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tsdf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [191:0]                 s_axis_tdata,
  // op
  input  logic                         s_axis_tuser,
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // force_x, force_y, force_z, length
  output logic [127:0]                 m_axis_tdata,
  // taut, saturated
  output logic [1:0]                   m_axis_tuser
);
  import tsdf_pkg::*;

  state_e state_q, state_d;

  logic [30:0] rest_q;
  logic [31:0] stiff_q, damp_q;
  logic [31:0] l0;

  logic [1:0]  ax_q;
  logic [6:0]  cnt_q;
  logic [31:0] dmag_q [3];
  logic [2:0]  dneg_q;
  logic        op_q;

  logic [65:0] sum_q;
  logic [63:0] src_q;
  logic [31:0] root_q;
  logic [34:0] srem_q;
  logic [34:0] s_r, s_t;
  logic        s_ge;
  logic [31:0] root_n;

  logic [31:0] len_q, prev_q, last_q, diff_q;
  logic        dmneg_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_q;

  logic [95:0] num_q;
  logic [31:0] rem_q, dvs_q;
  logic [32:0] d_r;
  logic        d_ge;
  logic [95:0] num_n;
  logic        div_run;

  logic [63:0] sp_q, dm_q, tm_q, lo_q;
  logic        tneg_q;
  logic [64:0] t_sum;

  logic [31:0] frc_q [3];
  logic        taut_q, sat_q;

  logic [31:0] out_f_q [3];
  logic [31:0] out_len_q;
  logic        out_taut_q, out_sat_q, out_valid_q;
  logic        out_load;

  logic        in_xfer;
  logic        f_neg;

  assign l0          = (rest_q == '0) ? 32'd1 : {1'b0, rest_q};
  assign in_xfer     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // square root step: two radicand bits per cycle
  assign s_r    = {srem_q[32:0], src_q[63:62]};
  assign s_t    = {1'b0, root_q, 2'b01};
  assign s_ge   = s_r >= s_t;
  assign root_n = {root_q[30:0], s_ge};

  // restoring divider step: one quotient bit per cycle
  assign d_r   = {rem_q, num_q[95]};
  assign d_ge  = d_r >= {1'b0, dvs_q};
  assign num_n = {num_q[94:0], d_ge};

  assign t_sum = {1'b0, sp_q} + {1'b0, dm_q};
  assign f_neg = tneg_q ^ dneg_q[ax_q];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_xfer) state_d = S_SQ_MUL;
      S_SQ_MUL:  state_d = S_SQ_ACC;
      S_SQ_ACC:  state_d = (ax_q == 2'd2) ? S_LEN : S_SQ_MUL;
      S_LEN:     state_d = (sum_q[65:64] != '0) ? S_CHECK : S_SQRT;
      S_SQRT:    if (cnt_q == 7'd1) state_d = S_CHECK;
      S_CHECK:   state_d = (op_q == OP_STEP && len_q > l0) ? S_SP_MUL : S_DONE;
      S_SP_MUL:  state_d = S_SP_LOAD;
      S_SP_LOAD: state_d = S_SP_DIV;
      S_SP_DIV:  if (cnt_q == 7'd1) state_d = (prev_q != '0) ? S_DM_MUL : S_TENSION;
      S_DM_MUL:  state_d = S_DM_LOAD;
      S_DM_LOAD: state_d = S_DM_DIV;
      S_DM_DIV:  if (cnt_q == 7'd1) state_d = S_TENSION;
      S_TENSION: state_d = S_F_LO;
      S_F_LO:    state_d = S_F_HI;
      S_F_HI:    state_d = S_F_LOAD;
      S_F_LOAD:  state_d = S_F_DIV;
      S_F_DIV:   if (cnt_q == 7'd1) state_d = S_F_SAT;
      S_F_SAT:   state_d = (ax_q == 2'd2) ? S_DONE : S_F_LO;
      S_DONE:    if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // control outputs: multiplier operands, handshake, divider enable, output load
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    s_axis_tready = 1'b0;
    div_run       = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      S_IDLE:   s_axis_tready = 1'b1;
      S_SQ_MUL: begin
        mul_a = dmag_q[ax_q];
        mul_b = dmag_q[ax_q];
      end
      S_SP_MUL: begin
        mul_a = stiff_q;
        mul_b = len_q - l0;
      end
      S_DM_MUL: begin
        mul_a = damp_q;
        mul_b = diff_q;
      end
      S_F_LO: begin
        mul_a = tm_q[31:0];
        mul_b = dmag_q[ax_q];
      end
      S_F_HI: begin
        mul_a = tm_q[63:32];
        mul_b = dmag_q[ax_q];
      end
      S_SP_DIV, S_DM_DIV, S_F_DIV: div_run = 1'b1;
      S_DONE:   out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rest_q      <= REST_LENGTH_RST[30:0];
      stiff_q     <= STIFFNESS_RST;
      damp_q      <= DAMPING_RST;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_REST_LENGTH: rest_q  <= cfg_data_i[30:0];
          REG_STIFFNESS:   stiff_q <= cfg_data_i;
          REG_DAMPING:     damp_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_CHECK) last_q <= len_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    logic [32:0] d;
    d     = '0;
    mul_q <= 64'(mul_a) * 64'(mul_b);
    if (div_run) begin
      rem_q <= d_ge ? 32'(d_r - {1'b0, dvs_q}) : d_r[31:0];
      num_q <= num_n;
      cnt_q <= cnt_q - 7'd1;
    end
    unique case (state_q)
      S_IDLE: if (in_xfer) begin
        for (int i = 0; i < 3; i++) begin
          d = {s_axis_tdata[96+32*i+31], s_axis_tdata[96+32*i +: 32]}
            - {s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]};
          dneg_q[i] <= d[32];
          dmag_q[i] <= d[32] ? 32'(-d) : d[31:0];
        end
        op_q  <= s_axis_tuser;
        sum_q <= '0;
        ax_q  <= '0;
        sat_q <= 1'b0;
      end
      S_SQ_ACC: begin
        sum_q <= sum_q + {2'b00, mul_q};
        ax_q  <= ax_q + 2'd1;
      end
      S_LEN: begin
        if (sum_q[65:64] != '0) begin
          len_q <= '1;
          sat_q <= 1'b1;
        end
        src_q  <= sum_q[63:0];
        root_q <= '0;
        srem_q <= '0;
        cnt_q  <= 7'd32;
      end
      S_SQRT: begin
        srem_q <= s_ge ? s_r - s_t : s_r;
        root_q <= root_n;
        src_q  <= {src_q[61:0], 2'b00};
        cnt_q  <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) len_q <= root_n;
      end
      S_CHECK: begin
        prev_q  <= last_q;
        diff_q  <= (len_q >= last_q) ? len_q - last_q : last_q - len_q;
        dmneg_q <= len_q < last_q;
        taut_q  <= 1'b0;
        for (int i = 0; i < 3; i++) frc_q[i] <= '0;
      end
      S_SP_LOAD: begin
        num_q <= {mul_q, 32'd0};
        rem_q <= '0;
        dvs_q <= l0;
        cnt_q <= 7'd64;
      end
      S_SP_DIV: if (cnt_q == 7'd1) begin
        sp_q <= num_n[63:0];
        dm_q <= '0;
        if (prev_q == '0) dmneg_q <= 1'b0;
      end
      S_DM_LOAD: begin
        num_q <= {mul_q, 32'd0};
        rem_q <= '0;
        dvs_q <= prev_q;
        cnt_q <= 7'd64;
      end
      S_DM_DIV: if (cnt_q == 7'd1) dm_q <= num_n[63:0];
      S_TENSION: begin
        ax_q   <= '0;
        taut_q <= 1'b1;
        tneg_q <= 1'b0;
        if (!dmneg_q) begin
          if (t_sum[64]) begin
            tm_q  <= '1;
            sat_q <= 1'b1;
          end else begin
            tm_q <= t_sum[63:0];
          end
        end else if (sp_q >= dm_q) begin
          tm_q <= sp_q - dm_q;
        end else begin
          tm_q   <= dm_q - sp_q;
          tneg_q <= 1'b1;
        end
      end
      S_F_HI: lo_q <= mul_q;
      S_F_LOAD: begin
        num_q <= {mul_q, 32'd0} + {32'd0, lo_q};
        rem_q <= '0;
        dvs_q <= len_q;
        cnt_q <= 7'd96;
      end
      S_F_SAT: begin
        if (f_neg) begin
          if (num_q > 96'h8000_0000) begin
            frc_q[ax_q] <= 32'h8000_0000;
            sat_q       <= 1'b1;
          end else begin
            frc_q[ax_q] <= 32'(-num_q[31:0]);
          end
        end else begin
          if (num_q > 96'h7FFF_FFFF) begin
            frc_q[ax_q] <= 32'h7FFF_FFFF;
            sat_q       <= 1'b1;
          end else begin
            frc_q[ax_q] <= num_q[31:0];
          end
        end
        ax_q <= ax_q + 2'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      for (int i = 0; i < 3; i++) out_f_q[i] <= frc_q[i];
      out_len_q  <= len_q;
      out_taut_q <= taut_q;
      out_sat_q  <= sat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_len_q, out_f_q[2], out_f_q[1], out_f_q[0]};
  assign m_axis_tuser  = {out_sat_q, out_taut_q};

  `TSDF_ASSERT_NXT(a_busy_after_xfer, in_xfer, !s_axis_tready)
  `TSDF_ASSERT_IMP(a_div_count_live, div_run, cnt_q != 7'd0)
  `TSDF_ASSERT(a_taut_longer, !(m_axis_tvalid && m_axis_tuser[0]) || (out_len_q > l0))

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Tension spring-damper force unit testbench
// Directed table then random rope positions under several flow-control
// phases; every result is checked against a table value or an in-bench force predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import tsdf_pkg::*;

  typedef struct packed {
    logic              op;
    logic signed [31:0] ax, ay, az, bx, by, bz;
  } rope_in_t;

  typedef struct packed {
    logic [31:0] fx, fy, fz;
    logic        taut;
    logic [31:0] len;
    logic        sat;
  } force_out_t;

  typedef struct {
    rope_in_t   stim;
    logic       has_exp;
    force_out_t exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  tension_spring_damper_force_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of registers and state
  logic [30:0] rest_q;
  logic [31:0] stiff_q, damp_q, prev_len_q;
  force_out_t expected_forces[$];
  int unsigned n_err = 0;
  int unsigned cycles = 0;
  int idle_pct = 0, stall_pct = 0;

  function automatic logic [31:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else res >>= 1;
      bitv >>= 2;
    end
    return res[31:0];
  endfunction

  function automatic force_out_t predict_force(input rope_in_t s);
    force_out_t o;
    logic signed [32:0] d[3];
    logic [32:0] dm_abs[3];
    logic [65:0] sum;
    logic [31:0] len, prev, l0, diff;
    logic [63:0] sp, dmp, tm;
    logic [95:0] q;
    logic [64:0] acc;
    logic dneg, tneg, neg;
    d[0] = 33'(s.bx) - 33'(s.ax);
    d[1] = 33'(s.by) - 33'(s.ay);
    d[2] = 33'(s.bz) - 33'(s.az);
    o = '0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      dm_abs[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      sum += 66'(dm_abs[i]) * 66'(dm_abs[i]);
    end
    if (sum[65:64] != 0) begin
      len = '1;
      o.sat = 1'b1;
    end else len = isqrt(sum[63:0]);
    prev = prev_len_q;
    prev_len_q = len;
    l0 = (rest_q == 0) ? 32'd1 : {1'b0, rest_q};
    o.len = len;
    if (s.op == OP_STEP && len > l0) begin
      sp = (64'(stiff_q) * 64'(len - l0)) / 64'(l0);
      dmp = 0;
      dneg = 1'b0;
      tneg = 1'b0;
      if (prev != 0) begin
        diff = (len >= prev) ? len - prev : prev - len;
        dneg = len < prev;
        dmp = (64'(damp_q) * 64'(diff)) / 64'(prev);
      end
      if (!dneg) begin
        acc = 65'(sp) + 65'(dmp);
        if (acc[64]) begin
          tm = '1;
          o.sat = 1'b1;
        end else tm = acc[63:0];
      end else if (sp >= dmp) tm = sp - dmp;
      else begin
        tm = dmp - sp;
        tneg = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        neg = tneg != d[i][32];
        q = (96'(tm) * 96'(dm_abs[i][31:0])) / 96'(len);
        if (neg) begin
          if (q > 96'h8000_0000) begin
            q = 96'h8000_0000;
            o.sat = 1'b1;
          end
          q = -q;
        end else if (q > 96'h7FFF_FFFF) begin
          q = 96'h7FFF_FFFF;
          o.sat = 1'b1;
        end
        if (i == 0) o.fx = q[31:0];
        else if (i == 1) o.fy = q[31:0];
        else o.fz = q[31:0];
      end
      o.taut = 1'b1;
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    n_err++;
  endtask

  // result monitor
  always @(posedge clk_i) begin
    force_out_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.fx = m_axis_tdata[31:0];
      got.fy = m_axis_tdata[63:32];
      got.fz = m_axis_tdata[95:64];
      got.len = m_axis_tdata[127:96];
      got.taut = m_axis_tuser[0];
      got.sat = m_axis_tuser[1];
      if (expected_forces.size() == 0) report_mismatch("unexpected", 0, 0);
      else begin
        want = expected_forces.pop_front();
        if (got.fx !== want.fx) report_mismatch("force_x", got.fx, want.fx);
        if (got.fy !== want.fy) report_mismatch("force_y", got.fy, want.fy);
        if (got.fz !== want.fz) report_mismatch("force_z", got.fz, want.fz);
        if (got.len !== want.len) report_mismatch("length", got.len, want.len);
        if (got.taut !== want.taut) report_mismatch("taut", got.taut, want.taut);
        if (got.sat !== want.sat) report_mismatch("saturated", got.sat, want.sat);
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 4000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_REST_LENGTH) rest_q = val[30:0];
    else if (idx == REG_STIFFNESS) stiff_q = val;
    else if (idx == REG_DAMPING) damp_q = val;
  endtask

  task automatic send_rope(input rope_in_t s, input logic has_exp, input force_out_t fixed);
    force_out_t p;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= s.op;
    s_axis_tdata <= {s.bz, s.by, s.bx, s.az, s.ay, s.ax};
    do @(posedge clk_i); while (!s_axis_tready);
    p = predict_force(s);
    expected_forces.push_back(has_exp ? fixed : p);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(input int span);
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 * span)) - span);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(2 * span)) - span) <<< 8;
    endcase
  endfunction

  row_t dir_rows[$];

  function automatic row_t mk(input logic op, input logic [31:0] ax, ay, az, bx, by, bz,
                              input logic he, input force_out_t e);
    row_t r;
    r.stim = '{op, ax, ay, az, bx, by, bz};
    r.has_exp = he;
    r.exp = e;
    return r;
  endfunction

  initial begin
    rope_in_t s;
    rest_q = REST_LENGTH_RST[30:0];
    stiff_q = STIFFNESS_RST;
    damp_q = DAMPING_RST;
    prev_len_q = '0;
    // prime at origin, zero length
    dir_rows.push_back(mk(OP_PRIME, 0, 0, 0, 0, 0, 0, 1, '0));
    // slack: length 0.5 under rest 1.0
    dir_rows.push_back(mk(OP_STEP, 0, 0, 0, 32'h8000, 0, 0, 1,
                          '{0, 0, 0, 0, 32'h8000, 0}));
    // taut 2.0 along x, k = 1: tension 1.0, force +1.0
    dir_rows.push_back(mk(OP_STEP, 0, 0, 0, 32'h2_0000, 0, 0, 1,
                          '{32'h1_0000, 0, 0, 1, 32'h2_0000, 0}));
    // extremes: length clips on all three axes
    dir_rows.push_back(mk(OP_PRIME, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                          '{0, 0, 0, 0, 32'hFFFF_FFFF, 1}));
    dir_rows.push_back(mk(OP_STEP, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 0, '0));
    dir_rows.push_back(mk(OP_STEP, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, '0));
    dir_rows.push_back(mk(OP_STEP, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, '0));
    dir_rows.push_back(mk(OP_STEP, 32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F,
                          32'hF0F0_F0F0, 32'h0123_4567, 32'h89AB_CDEF, 0, '0));
    dir_rows.push_back(mk(OP_STEP, 0, 0, 0, 0, 0, 1, 0, '0));
    dir_rows.push_back(mk(OP_STEP, 32'h5_0000, 32'h3_0000, 0, 0, 0, 32'h2_0000, 0, '0));
    dir_rows.push_back(mk(OP_STEP, 0, 0, 0, 32'h3_0000, 32'h4_0000, 0, 0, '0));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_rope(dir_rows[i].stim, dir_rows[i].has_exp, dir_rows[i].exp);
    drain();

    // damped, rest length zero, then stiffness, damping and rest length at extremes
    write_reg(REG_DAMPING, 32'h0001_0000);
    write_reg(REG_REST_LENGTH, 32'h0);
    foreach (dir_rows[i]) send_rope(dir_rows[i].stim, 0, '0);
    drain();
    write_reg(REG_STIFFNESS, 32'hFFFF_FFFF);
    write_reg(REG_DAMPING, 32'hFFFF_FFFF);
    write_reg(REG_REST_LENGTH, 32'h7FFF_FFFF);
    foreach (dir_rows[i]) send_rope(dir_rows[i].stim, 0, '0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      int span;
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 66; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 66; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      case (ph)
        0: write_reg(REG_REST_LENGTH, 32'h1_0000);
        3: write_reg(REG_REST_LENGTH, 32'h1);
        5: write_reg(REG_REST_LENGTH, $urandom());
        default: write_reg(REG_REST_LENGTH, $urandom_range(32'h40_0000, 1));
      endcase
      write_reg(REG_STIFFNESS, ph == 2 ? 32'h0 : (ph == 6 ? 32'hFFFF_FFFF : $urandom()));
      write_reg(REG_DAMPING, ph == 0 ? 32'h0 : (ph == 7 ? 32'hFFFF_FFFF : $urandom()));
      span = (ph % 2) ? 32'h7FFF_FFFF : 32'h80_0000;
      for (int n = 0; n < 190; n++) begin
        s.op = ($urandom_range(7) == 0) ? OP_PRIME : OP_STEP;
        s.ax = rand_coord(span); s.ay = rand_coord(span); s.az = rand_coord(span);
        s.bx = rand_coord(span); s.by = rand_coord(span); s.bz = rand_coord(span);
        send_rope(s, 0, '0);
      end
      drain();
    end

    if (n_err == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hdl
hdl/tsdf_pkg.sv
hdl/tension_spring_damper_force_unit.sv
verif/tb_top.sv
